[sv/shs_pkg.sv]
// Package for the session handshake supervisor.
// Holds acknowledgement, request and mode codes, and the state, item and result types.
// No dependencies.
package shs_pkg;

    // Peer acknowledgement codes carried in a status
    typedef enum logic [2:0] {
        ACK_BOOT_WAIT  = 3'd0,
        ACK_ACCEPTED   = 3'd1,
        ACK_READY      = 3'd2,
        ACK_ARMED      = 3'd3,
        ACK_ACTIVE     = 3'd4,
        ACK_RECOVERY   = 3'd5,
        ACK_FAULT_LOCK = 3'd6,
        ACK_REJECTED   = 3'd7
    } ack_t;

    // Request codes placed in a control frame
    typedef enum logic [2:0] {
        REQ_NONE          = 3'd0,
        REQ_ANNOUNCE      = 3'd1,
        REQ_SYNC_STANDBY  = 3'd2,
        REQ_COMMIT_ACTIVE = 3'd3,
        REQ_ACTIVE        = 3'd4
    } req_t;

    // Item selector
    typedef enum logic [1:0] {
        MODE_OBSERVE = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_FETCH   = 2'd2,
        MODE_BEGIN   = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic CFG_SESSION_ID    = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 48;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    typedef struct packed {
        logic [31:0] active_id;
        ack_t        last_ack;
        req_t        pending_request;
        logic [7:0]  frame_counter;
        logic        seen_flag;
        logic        recovery_latch;
        logic        fault_latch;
        logic [31:0] last_status_time;
    } shs_state_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] status_session_id;
        logic [2:0]  status_ack;
        logic [31:0] now;
    } shs_item_t;

    typedef struct packed {
        logic        status_matched;
        logic        frame_valid;
        logic [2:0]  frame_request;
        logic [31:0] frame_session_id;
        logic [7:0]  frame_sequence;
        logic        authorized;
        logic        error;
    } shs_result_t;

endpackage

[sv/session_handshake_supervisor.sv]
// Session handshake supervisor, gateway side. An accepted transaction is
// registered, then stepped through the combinational state update and
// written to the output register, so the block takes one transaction per
// cycle unless m_tready holds the output; the output register lets a new input
// be taken while a finished result waits for m_tready. The state update is
// combinational, and the next transaction sees the committed state at once.
// Uses shs_pkg and shs_step.
module session_handshake_supervisor import shs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata: status_session_id[31:0], status_ack[34:32], now[66:35], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]          s_tuser,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata: status_matched[0], frame_valid[1], frame_request[4:2],
    //        frame_session_id[36:5], frame_sequence[44:37], authorized[45],
    //        error[46], zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    logic        in_valid_reg;
    shs_item_t   item_reg;
    logic        out_valid_reg;
    shs_result_t result_reg;
    shs_state_t  state_reg;
    shs_state_t  state_next;
    shs_result_t result_next;
    logic [31:0] start_id_reg;
    logic [31:0] timeout_reg;
    logic        advance;
    logic        s_accept;

    // Move the held transaction forward when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_id_reg <= 32'd0;
            timeout_reg  <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_SESSION_ID) begin
                start_id_reg <= cfg_wdata;
            end else begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.mode              <= mode_t'(s_tuser);
            item_reg.status_session_id <= s_tdata[31:0];
            item_reg.status_ack        <= s_tdata[34:32];
            item_reg.now               <= s_tdata[66:35];
        end
    end

    shs_step u_step (
        .cur           (state_reg),
        .item          (item_reg),
        .start_id      (start_id_reg),
        .timeout_ticks (timeout_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    // Session state: commit on each advanced transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.active_id        <= 32'd0;
            state_reg.last_ack         <= ACK_BOOT_WAIT;
            state_reg.pending_request  <= REQ_NONE;
            state_reg.frame_counter    <= 8'd0;
            state_reg.seen_flag        <= 1'b0;
            state_reg.recovery_latch   <= 1'b0;
            state_reg.fault_latch      <= 1'b0;
            state_reg.last_status_time <= 32'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.error,
                       result_reg.authorized,
                       result_reg.frame_sequence,
                       result_reg.frame_session_id,
                       result_reg.frame_request,
                       result_reg.frame_valid,
                       result_reg.status_matched};

endmodule

[sv/shs_step.sv]
// Combinational step of the session handshake supervisor.
// Computes next session state and the result for one item; uses shs_pkg.
module shs_step import shs_pkg::*; (
    input  shs_state_t  cur,
    input  shs_item_t   item,
    input  logic [31:0] start_id,
    input  logic [31:0] timeout_ticks,
    output shs_state_t  nxt,
    output shs_result_t res
);

    ack_t        ack;
    logic [31:0] gap_before;
    logic [31:0] gap_after;

    assign ack        = ack_t'(item.status_ack);
    assign gap_before = item.now - cur.last_status_time;

    always_comb begin
        nxt = cur;
        res = '0;
        unique case (item.mode)
            MODE_OBSERVE: begin
                if (item.status_session_id != cur.active_id) begin
                    // status for another session
                    priority if (ack == ACK_BOOT_WAIT && item.status_session_id == 32'd0) begin
                        nxt.fault_latch     = 1'b0;
                        nxt.recovery_latch  = 1'b0;
                        nxt.frame_counter   = 8'd0;
                        nxt.pending_request = REQ_ANNOUNCE;
                        nxt.last_ack        = ACK_BOOT_WAIT;
                    end else if (ack == ACK_RECOVERY) begin
                        nxt.recovery_latch  = 1'b1;
                        nxt.pending_request = REQ_NONE;
                    end else if (ack == ACK_FAULT_LOCK) begin
                        nxt.fault_latch     = 1'b1;
                        nxt.recovery_latch  = 1'b0;
                        nxt.pending_request = REQ_NONE;
                    end else begin
                        nxt.last_ack = cur.last_ack;
                    end
                end else begin
                    // matching status: record it and pick the next request
                    res.status_matched   = 1'b1;
                    nxt.seen_flag        = 1'b1;
                    nxt.last_status_time = item.now;
                    nxt.last_ack         = ack;
                    unique case (ack)
                        ACK_ACCEPTED: begin
                            nxt.pending_request = REQ_SYNC_STANDBY;
                            nxt.recovery_latch  = 1'b0;
                        end
                        ACK_READY:  nxt.pending_request = REQ_SYNC_STANDBY;
                        ACK_ARMED:  nxt.pending_request = REQ_COMMIT_ACTIVE;
                        ACK_ACTIVE: nxt.pending_request = REQ_ACTIVE;
                        ACK_RECOVERY: begin
                            nxt.recovery_latch  = 1'b1;
                            nxt.pending_request = REQ_NONE;
                        end
                        ACK_FAULT_LOCK: begin
                            nxt.fault_latch     = 1'b1;
                            nxt.recovery_latch  = 1'b0;
                            nxt.pending_request = REQ_NONE;
                        end
                        ACK_BOOT_WAIT: nxt.pending_request = REQ_ANNOUNCE;
                        ACK_REJECTED:  nxt.pending_request = cur.pending_request;
                    endcase
                end
            end
            MODE_TICK: begin
                // clear the seen flag when the status gap exceeds the timeout; an active session goes to recovery
                if (cur.seen_flag && (gap_before > timeout_ticks)) begin
                    nxt.seen_flag = 1'b0;
                    if (cur.last_ack == ACK_ACTIVE) begin
                        nxt.last_ack        = ACK_RECOVERY;
                        nxt.recovery_latch  = 1'b1;
                        nxt.pending_request = REQ_NONE;
                    end
                end
            end
            MODE_FETCH: begin
                if (cur.active_id == 32'd0 || cur.pending_request == REQ_NONE) begin
                    res.error = 1'b1;
                end else begin
                    res.frame_valid      = 1'b1;
                    res.frame_request    = cur.pending_request;
                    res.frame_session_id = cur.active_id;
                    res.frame_sequence   = cur.frame_counter;
                    nxt.frame_counter    = cur.frame_counter + 8'd1;
                end
            end
            MODE_BEGIN: begin
                if (start_id == 32'd0) begin
                    res.error = 1'b1;
                end else begin
                    nxt.active_id       = start_id;
                    nxt.frame_counter   = 8'd0;
                    nxt.pending_request = REQ_ANNOUNCE;
                    nxt.last_ack        = ACK_BOOT_WAIT;
                    nxt.seen_flag       = 1'b0;
                    nxt.recovery_latch  = 1'b0;
                    nxt.fault_latch     = 1'b0;
                end
            end
        endcase

        // Authorization after the step, at the item's time
        gap_after      = item.now - nxt.last_status_time;
        res.authorized = !nxt.fault_latch && !nxt.recovery_latch && nxt.seen_flag &&
                         (nxt.last_ack == ACK_ACTIVE) && (gap_after <= timeout_ticks);
    end

endmodule
